/* rtl/sector_suppression_table_core_defines.svh */
// Shared assertion macros; every use expects clk and rst_n in scope.
`ifndef SECTOR_SUPPRESSION_TABLE_CORE_DEFINES_SVH
`define SECTOR_SUPPRESSION_TABLE_CORE_DEFINES_SVH

// Condition in this cycle implies a property in the same cycle.
`define SST_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sector table check failed in this cycle");

// Condition in this cycle implies a property in the next cycle.
`define SST_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sector table check failed one cycle later");

`endif

/* rtl/sst_pkg.sv */
package sst_pkg;

    localparam int SECTOR_COUNT  = 12;
    localparam int NEIGHBOR_SPAN = 1;
    localparam int SEC_W         = $clog2(SECTOR_COUNT);
    localparam int WALK_LEN      = 2 * NEIGHBOR_SPAN + 1;
    localparam int STEP_W        = $clog2(WALK_LEN + 1);
    // Adding this to an index and wrapping once lands on index - span.
    localparam int START_OFS     = SECTOR_COUNT - (NEIGHBOR_SPAN % SECTOR_COUNT);

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_HIT_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_HIT_TIMEOUT     = 2'd1;
    localparam logic [1:0] REG_RETRY_WINDOW    = 2'd2;
    localparam logic [1:0] REG_SUPPRESS_ENABLE = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] count;
        logic [31:0] hit_stamp;
        logic [31:0] retry_stamp;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             free;
        logic [SEC_W-1:0] idx;
        entry_t           data;
    } tbl_wr_t;

    function automatic logic [SEC_W-1:0] next_sector(input logic [SEC_W-1:0] s);
        logic [SEC_W-1:0] r;
        if (s == SEC_W'(SECTOR_COUNT - 1))
            r = '0;
        else
            r = s + SEC_W'(1);
        return r;
    endfunction

    function automatic logic [SEC_W-1:0] first_neighbor(input logic [SEC_W-1:0] s);
        logic [SEC_W:0] sum;
        logic [SEC_W:0] r;
        sum = {1'b0, s} + (SEC_W + 1)'(START_OFS);
        if (sum >= (SEC_W + 1)'(SECTOR_COUNT))
            r = sum - (SEC_W + 1)'(SECTOR_COUNT);
        else
            r = sum;
        return r[SEC_W-1:0];
    endfunction

endpackage

/* rtl/sst_age_cmp.sv */
module sst_age_cmp
    import sst_pkg::*;
(
    input  logic [31:0] now,
    input  logic [31:0] stamp,
    input  logic [31:0] limit,
    output logic        expired
);

    logic [31:0] age;

    // Modular age; wraps cleanly across the 32-bit time rollover.
    assign age     = now - stamp;
    assign expired = (age >= limit);

endmodule

/* rtl/sst_table.sv */
module sst_table
    import sst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear_all,
    input  tbl_wr_t          wr,
    input  logic [SEC_W-1:0] rd_idx,
    output entry_t           rd_data
);

    logic [SECTOR_COUNT-1:0] valid_reg;
    entry_t                  mem_reg [SECTOR_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= !wr.free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.free)
        begin
            mem_reg[wr.idx] <= wr.data;
        end
    end

    // An entry that is not valid reads as all zero.
    assign rd_data = valid_reg[rd_idx] ? mem_reg[rd_idx] : '0;

endmodule

/* rtl/sector_suppression_table_core.sv */
// Channel   Dir  Payload
// s_*       in   tuser[1:0] op; tdata[3:0] sector_index, [35:4] now_seconds
// m_*       out  tdata[0] allowed (check ops only)
// apb       in   hit_threshold 0x0, hit_timeout 0x4, retry_window 0x8, suppress_enable 0xC
//
// Mark: take the beat, then walk the neighbors (2*span+1) at one per cycle, one table write each.
// Check: take the beat, test hit age then retry age on the shared age comparator, walk the
// 2*span+1 neighbors, then load the output register; disabled or out-of-range checks go to ST_EMIT.
// Clear all: done as the beat is taken. The pace is set by the single age comparator and table port.
// Reset empties the table at once; s_tready stays low while an item is in work, also while a
// finished check waits in ST_EMIT for a free output register, but not once m_tvalid is up.
`include "sector_suppression_table_core_defines.svh"

module sector_suppression_table_core
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] sector_index, [35:4] now_seconds, [39:36] zero
    input  logic [1:0]  s_tuser,   // [1:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] allowed, [7:1] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_CK_HIT,
        ST_CK_RETRY,
        ST_WALK_FREE,
        ST_WALK_RETRY,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [SEC_W-1:0]  cur_reg, cur_next;
    logic [SEC_W-1:0]  start_reg, start_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       now_reg, now_next;
    logic              hit_stale_reg, hit_stale_next;
    logic              allow_reg, allow_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_allowed_reg, m_allowed_next;

    logic [15:0]       hit_threshold_reg;
    logic [31:0]       hit_timeout_reg;
    logic [31:0]       retry_window_reg;
    logic              suppress_enable_reg;

    logic              accepted;
    logic              sec_ok;
    logic [SEC_W-1:0]  in_idx;
    logic              last_step;
    logic              clear_all;
    tbl_wr_t           wr;
    entry_t            rd;
    logic [31:0]       unit_stamp;
    logic [31:0]       unit_limit;
    logic              expired;
    logic              cfg_write;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accepted  = s_tvalid && s_tready;
    assign sec_ok    = (s_tdata[3:0] < 4'(SECTOR_COUNT));
    assign in_idx    = SEC_W'(s_tdata[3:0]);
    assign last_step = (step_reg == STEP_W'(WALK_LEN - 1));

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_allowed_reg};

    sst_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .wr        (wr),
        .rd_idx    (cur_reg),
        .rd_data   (rd)
    );

    sst_age_cmp u_age (
        .now     (now_reg),
        .stamp   (unit_stamp),
        .limit   (unit_limit),
        .expired (expired)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        step_next      = step_reg;
        now_next       = now_reg;
        hit_stale_next = hit_stale_reg;
        allow_next     = allow_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_allowed_next = m_allowed_reg;
        clear_all      = 1'b0;
        wr             = '0;
        wr.idx         = cur_reg;
        unit_stamp     = rd.hit_stamp;
        unit_limit     = hit_timeout_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accepted)
                begin
                    now_next = s_tdata[35:4];
                    unique case (s_tuser)
                        OP_MARK:
                        begin
                            if (sec_ok)
                            begin
                                cur_next   = first_neighbor(in_idx);
                                step_next  = '0;
                                state_next = ST_MARK;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (!suppress_enable_reg)
                            begin
                                allow_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else if (!sec_ok)
                            begin
                                allow_next = 1'b0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cur_next   = in_idx;
                                start_next = first_neighbor(in_idx);
                                state_next = ST_CK_HIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clear_all = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MARK:
            begin
                // Expire stale hits first, then count and stamp.
                wr.en                = 1'b1;
                wr.data.hit_stamp    = now_reg;
                if (expired)
                begin
                    wr.data.count       = 16'd1;
                    wr.data.retry_stamp = '0;
                end
                else
                begin
                    wr.data.count       = (rd.count == COUNT_MAX) ? rd.count
                                                                  : rd.count + 16'd1;
                    wr.data.retry_stamp = rd.retry_stamp;
                end
                cur_next  = next_sector(cur_reg);
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_CK_HIT:
            begin
                hit_stale_next = expired;
                state_next     = ST_CK_RETRY;
            end

            ST_CK_RETRY:
            begin
                unit_stamp = rd.retry_stamp;
                unit_limit = retry_window_reg;
                allow_next = (rd.count < hit_threshold_reg) || hit_stale_reg || !expired;
                cur_next   = start_reg;
                step_next  = '0;
                state_next = ((rd.count < hit_threshold_reg) || hit_stale_reg || !expired)
                             ? ST_WALK_FREE : ST_WALK_RETRY;
            end

            ST_WALK_FREE:
            begin
                wr.en     = 1'b1;
                wr.free   = 1'b1;
                cur_next  = next_sector(cur_reg);
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_WALK_RETRY:
            begin
                wr.en               = 1'b1;
                wr.data             = rd;
                wr.data.retry_stamp = now_reg;
                cur_next            = next_sector(cur_reg);
                step_next           = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    m_allowed_next = allow_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            start_reg     <= '0;
            step_reg      <= '0;
            now_reg       <= '0;
            hit_stale_reg <= 1'b0;
            allow_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_allowed_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
            now_reg       <= now_next;
            hit_stale_reg <= hit_stale_next;
            allow_reg     <= allow_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_allowed_reg <= m_allowed_next;
        end
    end

    // Register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_threshold_reg   <= 16'd3;
            hit_timeout_reg     <= 32'd10;
            retry_window_reg    <= 32'd2;
            suppress_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_HIT_THRESHOLD:   hit_threshold_reg   <= pwdata[15:0];
                REG_HIT_TIMEOUT:     hit_timeout_reg     <= pwdata;
                REG_RETRY_WINDOW:    retry_window_reg    <= pwdata;
                REG_SUPPRESS_ENABLE: suppress_enable_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HIT_THRESHOLD:   prdata = {16'd0, hit_threshold_reg};
            REG_HIT_TIMEOUT:     prdata = hit_timeout_reg;
            REG_RETRY_WINDOW:    prdata = retry_window_reg;
            REG_SUPPRESS_ENABLE: prdata = {31'd0, suppress_enable_reg};
            default:             prdata = '0;
        endcase
    end

    `SST_ASSERT_NOW(a_cur_in_table, 1'b1, cur_reg < SEC_W'(SECTOR_COUNT))
    `SST_ASSERT_NOW(a_step_bounded, 1'b1, step_reg < STEP_W'(WALK_LEN))
    `SST_ASSERT_NEXT(a_mark_starts_walk, accepted && (s_tuser == OP_MARK) && sec_ok,
                     (state_reg == ST_MARK) && (step_reg == '0))
    `SST_ASSERT_NEXT(a_emit_loads_result, (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready),
                     m_tvalid_reg && (state_reg == ST_IDLE))

endmodule

/* tb/sector_suppression_table_core_test.sv */
`timescale 1ns / 100ps

module sector_suppression_table_core_test
    import sst_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [3:0] sector_index, [35:4] now_seconds, [39:36] zero
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] allowed, [7:1] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sector_suppression_table_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  sec;
        logic [31:0] secs;
        logic        typed;
        logic        want;
    } row_t;

    // Reset settings apply: threshold 3, timeout 10, retry window 2, suppression on.
    localparam int ROWS = 25;
    localparam row_t DIRECTED [ROWS] = '{
        '{OP_CHECK,  4'd0,  32'd0,          1'b1, 1'b1},  // empty table: allowed
        '{OP_CHECK,  4'd15, 32'd0,          1'b1, 1'b0},  // out of range: blocked
        '{OP_MARK,   4'd0,  32'd100,        1'b0, 1'b0},
        '{OP_MARK,   4'd0,  32'd100,        1'b0, 1'b0},
        '{OP_MARK,   4'd0,  32'd100,        1'b0, 1'b0},
        '{OP_CHECK,  4'd0,  32'd101,        1'b0, 1'b0},  // at threshold: blocked
        '{OP_CHECK,  4'd1,  32'd101,        1'b0, 1'b0},  // inside retry window
        '{OP_CHECK,  4'd0,  32'd102,        1'b0, 1'b0},
        '{OP_MARK,   4'd11, 32'hFFFF_FFFF,  1'b0, 1'b0},  // wraps to sector 0
        '{OP_MARK,   4'd11, 32'hFFFF_FFFF,  1'b0, 1'b0},
        '{OP_MARK,   4'd11, 32'hFFFF_FFFF,  1'b0, 1'b0},
        '{OP_CHECK,  4'd11, 32'd2,          1'b0, 1'b0},  // age across the time wrap
        '{OP_CHECK,  4'd10, 32'd3,          1'b0, 1'b0},
        '{OP_MARK,   4'd15, 32'd5,          1'b0, 1'b0},  // out of range mark: no effect
        '{OP_UNUSED, 4'd5,  32'd5,          1'b0, 1'b0},
        '{OP_MARK,   4'd5,  32'd50,         1'b0, 1'b0},
        '{OP_MARK,   4'd5,  32'd50,         1'b0, 1'b0},
        '{OP_MARK,   4'd5,  32'd50,         1'b0, 1'b0},
        '{OP_CLEAR,  4'd0,  32'd50,         1'b0, 1'b0},
        '{OP_CHECK,  4'd5,  32'd50,         1'b1, 1'b1},  // cleared table: allowed
        '{OP_MARK,   4'd6,  32'd60,         1'b0, 1'b0},
        '{OP_MARK,   4'd6,  32'd60,         1'b0, 1'b0},
        '{OP_MARK,   4'd6,  32'd60,         1'b0, 1'b0},
        '{OP_CHECK,  4'd6,  32'd75,         1'b0, 1'b0},  // stale hits
        '{OP_CHECK,  4'd12, 32'd0,          1'b1, 1'b0}
    };

    // Shadow of the suppression table and its registers.
    logic [15:0] sec_hits     [SECTOR_COUNT];
    logic [31:0] sec_hit_at   [SECTOR_COUNT];
    logic [31:0] sec_retry_at [SECTOR_COUNT];
    logic [15:0] cfg_threshold;
    logic [31:0] cfg_timeout;
    logic [31:0] cfg_window;
    logic        cfg_enable;

    bit allowed_q [$];
    int errors;
    int n_marks, n_checks, n_clears, n_blocked, n_results, n_settings;
    bit calm;

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int neighbor(input int s, input int d);
        return (s + d + SECTOR_COUNT * (NEIGHBOR_SPAN + 1)) % SECTOR_COUNT;
    endfunction

    function automatic void free_sector(input int s);
        sec_hits[s]     = '0;
        sec_hit_at[s]   = '0;
        sec_retry_at[s] = '0;
    endfunction

    function automatic void table_step(input logic [1:0] op, input logic [3:0] sec,
                                       input logic [31:0] t_now, output bit has_res,
                                       output bit ok);
        bit in_range;
        int s;
        in_range = sec < SECTOR_COUNT;
        has_res = 1'b0;
        ok = 1'b0;
        case (op)
            OP_MARK:
            begin
                if (in_range)
                    for (int d = -NEIGHBOR_SPAN; d <= NEIGHBOR_SPAN; d++)
                    begin
                        s = neighbor(sec, d);
                        if (32'(t_now - sec_hit_at[s]) >= cfg_timeout)
                            free_sector(s);
                        if (sec_hits[s] != COUNT_MAX)
                            sec_hits[s] = sec_hits[s] + 16'd1;
                        sec_hit_at[s] = t_now;
                    end
            end
            OP_CHECK:
            begin
                has_res = 1'b1;
                if (!cfg_enable)
                    ok = 1'b1;
                else if (!in_range)
                    ok = 1'b0;
                else if (sec_hits[sec] < cfg_threshold ||
                         32'(t_now - sec_hit_at[sec]) >= cfg_timeout ||
                         32'(t_now - sec_retry_at[sec]) < cfg_window)
                begin
                    for (int d = -NEIGHBOR_SPAN; d <= NEIGHBOR_SPAN; d++)
                        free_sector(neighbor(sec, d));
                    ok = 1'b1;
                end
                else
                begin
                    for (int d = -NEIGHBOR_SPAN; d <= NEIGHBOR_SPAN; d++)
                        sec_retry_at[neighbor(sec, d)] = t_now;
                    ok = 1'b0;
                end
            end
            OP_CLEAR:
                for (int s2 = 0; s2 < SECTOR_COUNT; s2++)
                    free_sector(s2);
            default: ;
        endcase
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(0, 99) < 18);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch: %s, expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // Result side: check accepted beats, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (allowed_q.size() == 0)
                report_mismatch("result with nothing pending", -1, m_tdata[0]);
            else if (m_tdata[0] !== allowed_q[0])
                report_mismatch("allowed", allowed_q.pop_front(), m_tdata[0]);
            else
                void'(allowed_q.pop_front());
        end
        m_tready <= !roll_idle();
    end

    task automatic send_item(input logic [1:0] op, input logic [3:0] sec,
                             input logic [31:0] t_now, input bit typed, input bit want);
        bit has_res;
        bit ok;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, t_now, sec};
        do
            @(posedge clk);
        while (!s_tready);
        table_step(op, sec, t_now, has_res, ok);
        if (has_res)
        begin
            allowed_q.push_back(typed ? want : ok);
            if (!ok)
                n_blocked++;
        end
        case (op)
            OP_MARK:  n_marks++;
            OP_CHECK: n_checks++;
            OP_CLEAR: n_clears++;
            default: ;
        endcase
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Hold the input side until every pending result is out, then let marks finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (allowed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves psel high; the caller releases the bus after the last write.
    task automatic apb_write(input logic [1:0] reg_id, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (reg_id)
            REG_HIT_THRESHOLD:   cfg_threshold = value[15:0];
            REG_HIT_TIMEOUT:     cfg_timeout   = value;
            REG_RETRY_WINDOW:    cfg_window    = value;
            REG_SUPPRESS_ENABLE: cfg_enable    = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [31:0] tmo,
                                  input logic [31:0] win, input logic en);
        apb_write(REG_HIT_THRESHOLD, {16'b0, thr});
        apb_write(REG_HIT_TIMEOUT, tmo);
        apb_write(REG_RETRY_WINDOW, win);
        apb_write(REG_SUPPRESS_ENABLE, {31'b0, en});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] step_clock(input logic [31:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return t;
        if (r < 85)
            return t + $urandom_range(1, 3);
        if (r < 97)
            return t + $urandom_range(4, 25);
        return $urandom();
    endfunction

    // Mostly bursts of marks and checks around one focus sector, with noise mixed in.
    task automatic random_run(input int count, input logic [31:0] start);
        logic [31:0] t;
        logic [3:0]  focus;
        logic [1:0]  op;
        logic [3:0]  sec;
        int r;
        t = start;
        focus = 4'($urandom_range(0, SECTOR_COUNT - 1));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 14) == 0)
                focus = 4'($urandom_range(0, SECTOR_COUNT - 1));
            t = step_clock(t);
            if ($urandom_range(0, 99) < 75)
            begin
                op  = ($urandom_range(0, 99) < 55) ? OP_MARK : OP_CHECK;
                sec = 4'(neighbor(focus, $urandom_range(0, 2) - 1));
            end
            else
            begin
                r = $urandom_range(0, 99);
                op  = (r < 40) ? OP_MARK : (r < 80) ? OP_CHECK : (r < 88) ? OP_CLEAR : OP_UNUSED;
                sec = 4'($urandom_range(0, 15));
            end
            send_item(op, sec, t, 1'b0, 1'b0);
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                drain();
            else if (roll_idle())
                sender_gap();
        end
        drain();
    endtask

    initial
    begin
        int waited;
        clk      = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        errors = 0;
        calm = 1'b0;
        cfg_threshold = 16'd3;
        cfg_timeout   = 32'd10;
        cfg_window    = 32'd2;
        cfg_enable    = 1'b1;
        for (int s = 0; s < SECTOR_COUNT; s++)
            free_sector(s);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_item(DIRECTED[i].op, DIRECTED[i].sec, DIRECTED[i].secs,
                      DIRECTED[i].typed, DIRECTED[i].want);
            if (roll_idle())
                sender_gap();
        end
        drain();

        apply_settings(16'd3, 32'd10, 32'd2, 1'b1);
        random_run(300, $urandom());
        // Extremes: zero threshold, no expiry, no retry window; then full threshold, instant expiry, endless window.
        apply_settings(16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
        random_run(120, 32'hFFFF_FFF0);
        apply_settings(16'hFFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
        random_run(100, $urandom());
        apply_settings(16'($urandom_range(1, 5)), $urandom_range(3, 30),
                       $urandom_range(0, 6), 1'b0);
        random_run(150, $urandom());
        apply_settings(16'($urandom_range(1, 5)), $urandom_range(3, 30),
                       $urandom_range(0, 6), 1'b1);
        calm = 1'b1;
        random_run(350, $urandom());
        calm = 1'b0;
        apply_settings(16'($urandom_range(1, 5)), $urandom_range(3, 30),
                       $urandom_range(0, 6), 1'b1);
        random_run(350, $urandom());

        waited = 0;
        while (allowed_q.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (allowed_q.size() != 0)
            report_mismatch("results never delivered", 0, allowed_q.size());
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d marks, %0d checks (%0d blocked), %0d clears", n_marks,
                 n_checks, n_blocked, n_clears);
        $display("across %0d register settings, %0d results compared", n_settings + 1,
                 n_results);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
